[hw/rtl/tmpg_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tmpg_pkg
// Shared field widths, function codes and pixel constants of the text-mode
// pixel generator.
// ---------------------------------------------------------------------------
package tmpg_pkg;

  localparam int FUNC_W       = 2;
  localparam int ROW_W        = 4;
  localparam int COL_W        = 5;
  localparam int CODE_W       = 8;
  localparam int FADDR_W      = 14;
  localparam int BYTE_W       = 8;
  localparam int LINE_W       = 9;
  localparam int BCOL_W       = 7;
  localparam int PIX_W        = 2;
  localparam int PIX_PER_BYTE = 4;
  localparam int NUM_CODES    = 2 ** CODE_W;
  localparam int NUM_STAGES   = 6;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CELL_WR = 2'd0,
    FUNC_FONT_WR = 2'd1,
    FUNC_READ    = 2'd2
  } func_t;

  typedef logic [PIX_W-1:0] pixel_t;

endpackage

[hw/rtl/tmpg_cmd_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tmpg_cmd_if
// Command channel: cell writes, font writes and frame byte reads.
// ---------------------------------------------------------------------------
interface tmpg_cmd_if;

  logic                          valid;
  logic                          ready;
  logic [tmpg_pkg::FUNC_W-1:0]   func;
  logic [tmpg_pkg::ROW_W-1:0]    cell_row;
  logic [tmpg_pkg::COL_W-1:0]    cell_column;
  logic [tmpg_pkg::CODE_W-1:0]   char_code;
  logic [tmpg_pkg::FADDR_W-1:0]  font_address;
  logic [tmpg_pkg::BYTE_W-1:0]   font_byte;
  logic [tmpg_pkg::LINE_W-1:0]   scan_line;
  logic [tmpg_pkg::BCOL_W-1:0]   byte_column;

  modport source (
    output valid, func, cell_row, cell_column, char_code, font_address, font_byte,
           scan_line, byte_column,
    input  ready
  );

  modport sink (
    input  valid, func, cell_row, cell_column, char_code, font_address, font_byte,
           scan_line, byte_column,
    output ready
  );

endinterface

[hw/rtl/tmpg_res_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tmpg_res_if
// Result channel: one frame byte of four pixels with its line and column.
// ---------------------------------------------------------------------------
interface tmpg_res_if;

  logic                         valid;
  logic                         ready;
  logic [tmpg_pkg::BYTE_W-1:0]  pixels;
  logic [tmpg_pkg::LINE_W-1:0]  out_line;
  logic [tmpg_pkg::BCOL_W-1:0]  out_column;

  modport source (
    output valid, pixels, out_line, out_column,
    input  ready
  );

  modport sink (
    input  valid, pixels, out_line, out_column,
    output ready
  );

endinterface

[hw/rtl/tmpg_cdiv.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tmpg_cdiv
// Two-stage divider by a constant: reciprocal multiply, then one
// compare-and-subtract correction.
// ---------------------------------------------------------------------------
module tmpg_cdiv #(
  parameter int DIVISOR = 3,
  parameter int IN_W    = 14,
  parameter int R_W     = (DIVISOR > 1) ? $clog2(DIVISOR) : 1
) (
  input  logic            clk,
  input  logic            en_mul,
  input  logic            en_fix,
  input  logic [IN_W-1:0] dividend,
  output logic [IN_W-1:0] quotient,
  output logic [R_W-1:0]  remainder
);

  localparam int SHIFT = IN_W + $clog2(DIVISOR) + 1;
  localparam int MW    = SHIFT + 1;
  localparam int PW    = IN_W + MW;
  localparam logic [MW-1:0] RECIP = MW'((64'd1 << SHIFT) / DIVISOR);

  logic [PW-1:0]   product;
  logic [IN_W-1:0] dividend_d;
  logic [IN_W-1:0] q_est;
  logic [IN_W-1:0] back;
  logic [IN_W-1:0] rem;
  logic            fix;

  always_ff @(posedge clk) begin
    if (en_mul) begin
      product    <= PW'(dividend) * PW'(RECIP);
      dividend_d <= dividend;
    end
  end

  // estimate is exact or one short
  always_comb begin
    q_est = product[SHIFT +: IN_W];
    back  = IN_W'(q_est * DIVISOR);
    rem   = dividend_d - back;
    fix   = (rem >= DIVISOR);
  end

  always_ff @(posedge clk) begin
    if (en_fix) begin
      quotient  <= fix ? q_est + 1'b1 : q_est;
      remainder <= fix ? R_W'(rem - IN_W'(DIVISOR)) : R_W'(rem);
    end
  end

endmodule

[hw/rtl/text_mode_pixel_generator.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// text_mode_pixel_generator
// Text-mode character generator, 2 bits per pixel. Holds a character map
// and a row-organized font memory; read transactions return one frame byte.
// ---------------------------------------------------------------------------
// six-stage pipeline, one transaction accepted per cycle when not stalled
// read result becomes valid on res when the read reaches the last stage
// map and font writes take effect in transaction order for later reads
// stall from res.ready propagates back stage by stage, bubbles are squeezed
// reset clears stage valids and transparent code; map and font are not cleared
// ---------------------------------------------------------------------------
module text_mode_pixel_generator #(
  parameter int VIDEO_W  = 360,
  parameter int VIDEO_H  = 288,
  parameter int MAP_ROWS = 16,
  parameter int MAP_COLS = 30,
  parameter int GLYPH_W  = 12,
  parameter int GLYPH_H  = 18
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [tmpg_pkg::PIX_W-1:0] cfg_wdata,
  tmpg_cmd_if.sink                   cmd,
  tmpg_res_if.source                 res
);

  localparam int ROW_BYTES = (GLYPH_W * 2 + 7) / 8;
  localparam int ROW_BITS  = ROW_BYTES * tmpg_pkg::BYTE_W;
  localparam int FONT_ROWS = tmpg_pkg::NUM_CODES * GLYPH_H;
  localparam int FONT_BYTES = FONT_ROWS * ROW_BYTES;
  localparam int MAP_CELLS = MAP_ROWS * MAP_COLS;
  localparam int MI_W      = (MAP_CELLS > 1) ? $clog2(MAP_CELLS) : 1;
  localparam int FR_W      = $clog2(FONT_ROWS);
  localparam int RB_W      = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam int GR_W      = $clog2(GLYPH_H);
  localparam int GC_W      = $clog2(GLYPH_W);
  localparam int PB_W      = $clog2(ROW_BITS);
  localparam int X_W       = tmpg_pkg::BCOL_W + 2;
  localparam int NS        = tmpg_pkg::NUM_STAGES;
  localparam int NP        = tmpg_pkg::PIX_PER_BYTE;
  localparam int PW        = tmpg_pkg::PIX_W;

  typedef struct packed {
    logic                           cell_wr;
    logic                           font_wr;
    logic                           rd;
    logic                           cell_ok;
    logic                           font_ok;
    logic                           y_ok;
    logic [NP-1:0]                  x_ok;
    logic [tmpg_pkg::ROW_W-1:0]     cell_row;
    logic [tmpg_pkg::COL_W-1:0]     cell_column;
    logic [tmpg_pkg::CODE_W-1:0]    char_code;
    logic [tmpg_pkg::FADDR_W-1:0]   font_address;
    logic [tmpg_pkg::BYTE_W-1:0]    font_byte;
    logic [tmpg_pkg::LINE_W-1:0]    line;
    logic [tmpg_pkg::BCOL_W-1:0]    bcol;
  } item_t;

  typedef logic [ROW_BYTES-1:0][tmpg_pkg::BYTE_W-1:0] font_row_t;

  // stage control
  logic [NS:1] vld;
  logic [NS:1] rdy;

  // configuration
  tmpg_pkg::pixel_t tcode;

  // stage payload
  item_t item_in;
  item_t it1, it2, it3, it4, it5;

  // divider results, stage 3
  logic [tmpg_pkg::LINE_W-1:0]  mrow3;
  logic [GR_W-1:0]              grow3;
  logic [X_W-1:0]               mcol3;
  logic [GC_W-1:0]              gcol3;
  logic [tmpg_pkg::FADDR_W-1:0] frow3;
  logic [RB_W-1:0]              flane3;

  // map access, stage 3 to 4
  logic [X_W-1:0]       mcol_b;
  logic                 row_ok;
  logic                 a_ok;
  logic                 b_ok;
  logic [MI_W-1:0]      idx_a;
  logic [MI_W-1:0]      idx_b;
  logic [MI_W-1:0]      wr_idx;
  logic [GC_W:0]        gsum;
  logic [NP-1:0]        wrap_next;
  logic [NP-1:0]        ok_next;
  logic [NP-1:0][GC_W-1:0] gcol_next;

  logic [tmpg_pkg::CODE_W-1:0] char_map [MAP_CELLS];

  // stage 4
  logic [tmpg_pkg::CODE_W-1:0]  code_a4;
  logic [tmpg_pkg::CODE_W-1:0]  code_b4;
  logic [GR_W-1:0]              grow4;
  logic [tmpg_pkg::FADDR_W-1:0] frow4;
  logic [RB_W-1:0]              flane4;
  logic [NP-1:0]                wrap4;
  logic [NP-1:0]                ok4;
  logic [NP-1:0][GC_W-1:0]      gcol4;
  logic [FR_W-1:0]              fidx_a;
  logic [FR_W-1:0]              fidx_b;

  font_row_t font_mem [FONT_ROWS];

  // stage 5
  font_row_t                    row_a5;
  font_row_t                    row_b5;
  logic [NP-1:0]                wrap5;
  logic [NP-1:0]                ok5;
  logic [NP-1:0][GC_W-1:0]      gcol5;
  logic [tmpg_pkg::BYTE_W-1:0]  pixels_next;

  // ready chain, back to front
  always_comb begin
    rdy[NS] = !vld[NS] || res.ready;
    for (int i = NS - 1; i >= 1; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign cmd.ready = rdy[1];
  assign res.valid = vld[NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      tcode <= '0;
    end else begin
      if (cfg_we) begin
        tcode <= cfg_wdata;
      end
      if (rdy[1]) begin
        vld[1] <= cmd.valid;
      end
      for (int i = 2; i < NS; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
      // only reads produce a result
      if (rdy[NS]) begin
        vld[NS] <= vld[NS-1] && it5.rd;
      end
    end
  end

  // decode and range checks at entry
  always_comb begin
    item_in              = '0;
    item_in.cell_row     = cmd.cell_row;
    item_in.cell_column  = cmd.cell_column;
    item_in.char_code    = cmd.char_code;
    item_in.font_address = cmd.font_address;
    item_in.font_byte    = cmd.font_byte;
    item_in.line         = cmd.scan_line;
    item_in.bcol         = cmd.byte_column;
    unique case (cmd.func)
      tmpg_pkg::FUNC_CELL_WR: item_in.cell_wr = 1'b1;
      tmpg_pkg::FUNC_FONT_WR: item_in.font_wr = 1'b1;
      tmpg_pkg::FUNC_READ:    item_in.rd      = 1'b1;
      default: ;
    endcase
    item_in.cell_ok = (cmd.cell_row < MAP_ROWS) && (cmd.cell_column < MAP_COLS);
    item_in.font_ok = (cmd.font_address < FONT_BYTES);
    item_in.y_ok    = (cmd.scan_line < VIDEO_H);
    for (int k = 0; k < NP; k++) begin
      item_in.x_ok[k] = ((X_W+1)'({cmd.byte_column, 2'b00}) + (X_W+1)'(k)) < VIDEO_W;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) it1 <= item_in;
    if (rdy[2]) it2 <= it1;
    if (rdy[3]) it3 <= it2;
    if (rdy[4]) it4 <= it3;
    if (rdy[5]) it5 <= it4;
  end

  tmpg_cdiv #(
    .DIVISOR (GLYPH_H),
    .IN_W    (tmpg_pkg::LINE_W),
    .R_W     (GR_W)
  ) u_line_div (
    .clk       (clk),
    .en_mul    (rdy[2]),
    .en_fix    (rdy[3]),
    .dividend  (it1.line),
    .quotient  (mrow3),
    .remainder (grow3)
  );

  tmpg_cdiv #(
    .DIVISOR (GLYPH_W),
    .IN_W    (X_W),
    .R_W     (GC_W)
  ) u_x_div (
    .clk       (clk),
    .en_mul    (rdy[2]),
    .en_fix    (rdy[3]),
    .dividend  ({it1.bcol, 2'b00}),
    .quotient  (mcol3),
    .remainder (gcol3)
  );

  tmpg_cdiv #(
    .DIVISOR (ROW_BYTES),
    .IN_W    (tmpg_pkg::FADDR_W),
    .R_W     (RB_W)
  ) u_addr_div (
    .clk       (clk),
    .en_mul    (rdy[2]),
    .en_fix    (rdy[3]),
    .dividend  (it1.font_address),
    .quotient  (frow3),
    .remainder (flane3)
  );

  // cell lookup: four pixels touch at most two cells
  always_comb begin
    mcol_b = mcol3 + 1'b1;
    row_ok = (mrow3 < MAP_ROWS);
    a_ok   = it3.y_ok && row_ok && (mcol3 < MAP_COLS);
    b_ok   = it3.y_ok && row_ok && (mcol_b < MAP_COLS);
    idx_a  = a_ok ? MI_W'(mrow3 * MAP_COLS + mcol3) : '0;
    idx_b  = b_ok ? MI_W'(mrow3 * MAP_COLS + mcol_b) : '0;
    wr_idx = MI_W'(it3.cell_row * MAP_COLS + it3.cell_column);
    gsum   = '0;
    for (int k = 0; k < NP; k++) begin
      gsum         = (GC_W+1)'(gcol3) + (GC_W+1)'(k);
      wrap_next[k] = (gsum >= GLYPH_W);
      gcol_next[k] = wrap_next[k] ? GC_W'(gsum - (GC_W+1)'(GLYPH_W)) : GC_W'(gsum);
      ok_next[k]   = it3.x_ok[k] && (wrap_next[k] ? b_ok : a_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      code_a4 <= char_map[idx_a];
      code_b4 <= char_map[idx_b];
      grow4   <= grow3;
      frow4   <= frow3;
      flane4  <= flane3;
      wrap4   <= wrap_next;
      ok4     <= ok_next;
      gcol4   <= gcol_next;
    end
    if (rdy[4] && vld[3] && it3.cell_wr && it3.cell_ok) begin
      char_map[wr_idx] <= it3.char_code;
    end
  end

  // glyph row lookup
  always_comb begin
    fidx_a = FR_W'(code_a4 * GLYPH_H + grow4);
    fidx_b = FR_W'(code_b4 * GLYPH_H + grow4);
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      row_a5 <= font_mem[fidx_a];
      row_b5 <= font_mem[fidx_b];
      wrap5  <= wrap4;
      ok5    <= ok4;
      gcol5  <= gcol4;
    end
    if (rdy[5] && vld[4] && it4.font_wr && it4.font_ok) begin
      font_mem[FR_W'(frow4)][flane4] <= it4.font_byte;
    end
  end

  // pixel extraction, leftmost pixel in the top bits
  always_comb begin
    logic [ROW_BITS-1:0] word;
    logic [PB_W-1:0]     pos;
    tmpg_pkg::pixel_t    pix;
    pixels_next = '0;
    word        = '0;
    pos         = '0;
    pix         = '0;
    for (int k = 0; k < NP; k++) begin
      word = wrap5[k] ? row_b5 : row_a5;
      pos  = PB_W'({gcol5[k], 1'b0} ^ (GC_W+1)'(6));
      pix  = word[pos +: PW];
      pixels_next[(NP-1-k)*PW +: PW] = ok5[k] ? pix : tcode;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NS]) begin
      res.pixels     <= pixels_next;
      res.out_line   <= it5.line;
      res.out_column <= it5.bcol;
    end
  end

  // checks
  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !res.valid)
    else $error("result valid right after reset");

  a_stall_means_full: assert property (@(posedge clk) disable iff (rst)
    !cmd.ready |-> ((&vld) && !res.ready))
    else $error("command stalled with a free stage");

  a_writes_give_no_result: assert property (@(posedge clk) disable iff (rst)
    (vld[NS-1] && rdy[NS] && !it5.rd) |=> !vld[NS])
    else $error("non-read transaction produced a result");

  a_remainders_in_range: assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> ((grow3 < GLYPH_H) && (gcol3 < GLYPH_W)))
    else $error("divider remainder out of range");

endmodule

[bench/tmpg_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tmpg_checker
// Watches the command and result channels of the text-mode pixel generator,
// keeps its own copy of the character map, font memory and transparent code,
// predicts each frame byte and compares it field by field in order.
// ---------------------------------------------------------------------------
module tmpg_checker #(
  parameter int VIDEO_W  = 360,
  parameter int VIDEO_H  = 288,
  parameter int MAP_ROWS = 16,
  parameter int MAP_COLS = 30,
  parameter int GLYPH_W  = 12,
  parameter int GLYPH_H  = 18
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [tmpg_pkg::PIX_W-1:0] cfg_wdata,
  tmpg_cmd_if                        cmd,
  tmpg_res_if                        res,
  output int                         mismatch_count,
  output int                         outstanding
);

  localparam int PIX_W        = tmpg_pkg::PIX_W;
  localparam int PIX_PER_BYTE = tmpg_pkg::PIX_PER_BYTE;
  localparam int NUM_CODES    = tmpg_pkg::NUM_CODES;
  localparam int BYTE_W       = tmpg_pkg::BYTE_W;
  localparam int LINE_W       = tmpg_pkg::LINE_W;
  localparam int BCOL_W       = tmpg_pkg::BCOL_W;
  localparam int CODE_W       = tmpg_pkg::CODE_W;

  localparam int ROW_BYTES   = (GLYPH_W * PIX_W + 7) / 8;
  localparam int GLYPH_BYTES = GLYPH_H * ROW_BYTES;
  localparam int FONT_BYTES  = NUM_CODES * GLYPH_BYTES;
  localparam int MAP_CELLS   = MAP_ROWS * MAP_COLS;

  typedef tmpg_pkg::pixel_t pixel_t;

  typedef struct packed {
    logic [BYTE_W-1:0] pixels;
    logic [LINE_W-1:0] line;
    logic [BCOL_W-1:0] column;
  } frame_byte_t;

  logic [CODE_W-1:0] char_map    [MAP_CELLS];
  logic [BYTE_W-1:0] font_memory [FONT_BYTES];
  pixel_t            transparent_code;
  frame_byte_t       expected_bytes [$];
  int                mismatches = 0;

  assign mismatch_count = mismatches;

  task automatic report_mismatch(input string msg);
    $display("[%0t] %s", $time, msg);
    mismatches++;
  endtask

  function automatic pixel_t glyph_pixel(int unsigned x, int unsigned y);
    int unsigned code;
    int unsigned addr;
    int unsigned bit_pos;
    if (x >= VIDEO_W || y >= VIDEO_H) return transparent_code;
    if (y / GLYPH_H >= MAP_ROWS || x / GLYPH_W >= MAP_COLS) return transparent_code;
    code    = char_map[(y / GLYPH_H) * MAP_COLS + x / GLYPH_W];
    bit_pos = (x % GLYPH_W) * PIX_W;
    addr    = code * GLYPH_BYTES + (y % GLYPH_H) * ROW_BYTES + bit_pos / 8;
    if (addr >= FONT_BYTES) return transparent_code;
    return pixel_t'(font_memory[addr] >> (8 - PIX_W - bit_pos % 8));
  endfunction

  function automatic frame_byte_t predict_frame_byte(logic [LINE_W-1:0] line,
                                                     logic [BCOL_W-1:0] column);
    frame_byte_t fb;
    fb.line   = line;
    fb.column = column;
    fb.pixels = '0;
    for (int k = 0; k < PIX_PER_BYTE; k++)
      fb.pixels[BYTE_W-1-PIX_W*k -: PIX_W] = glyph_pixel(column * PIX_PER_BYTE + k, line);
    return fb;
  endfunction

  always @(posedge clk) begin
    frame_byte_t want;
    if (rst) begin
      transparent_code = '0;
      expected_bytes.delete();
    end else begin
      if (cfg_we) transparent_code = cfg_wdata;
      // results first, so a byte can never match a read accepted at the same edge
      if (res.valid && res.ready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected frame byte line %0d column %0d",
                                    res.out_line, res.out_column));
        end else begin
          want = expected_bytes.pop_front();
          if (res.pixels !== want.pixels)
            report_mismatch($sformatf("pixels line %0d column %0d: got %h expected %h",
                                      want.line, want.column, res.pixels,
                                      want.pixels));
          if (res.out_line !== want.line)
            report_mismatch($sformatf("out_line: got %0d expected %0d",
                                      res.out_line, want.line));
          if (res.out_column !== want.column)
            report_mismatch($sformatf("out_column: got %0d expected %0d",
                                      res.out_column, want.column));
        end
      end
      if (cmd.valid && cmd.ready) begin
        case (cmd.func)
          tmpg_pkg::FUNC_CELL_WR: begin
            if (cmd.cell_row < MAP_ROWS && cmd.cell_column < MAP_COLS)
              char_map[cmd.cell_row * MAP_COLS + cmd.cell_column] = cmd.char_code;
          end
          tmpg_pkg::FUNC_FONT_WR: begin
            if (cmd.font_address < FONT_BYTES)
              font_memory[cmd.font_address] = cmd.font_byte;
          end
          tmpg_pkg::FUNC_READ: begin
            expected_bytes.push_back(predict_frame_byte(cmd.scan_line, cmd.byte_column));
          end
          default: ;
        endcase
      end
    end
    outstanding <= expected_bytes.size();
  end

endmodule

[bench/tb_text_mode_pixel_generator.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_text_mode_pixel_generator
// Loads character cells and font bytes, then reads frame bytes across the
// screen and outside it, under several transparent codes, with random gaps
// and stalls on both channels. A side checker predicts and compares.
// ---------------------------------------------------------------------------
module tb_text_mode_pixel_generator;

  localparam int VIDEO_W  = 360;
  localparam int VIDEO_H  = 288;
  localparam int MAP_ROWS = 16;
  localparam int MAP_COLS = 30;
  localparam int GLYPH_W  = 12;
  localparam int GLYPH_H  = 18;

  localparam int FUNC_W       = tmpg_pkg::FUNC_W;
  localparam int ROW_W        = tmpg_pkg::ROW_W;
  localparam int COL_W        = tmpg_pkg::COL_W;
  localparam int CODE_W       = tmpg_pkg::CODE_W;
  localparam int FADDR_W      = tmpg_pkg::FADDR_W;
  localparam int BYTE_W       = tmpg_pkg::BYTE_W;
  localparam int LINE_W       = tmpg_pkg::LINE_W;
  localparam int BCOL_W       = tmpg_pkg::BCOL_W;
  localparam int PIX_W        = tmpg_pkg::PIX_W;
  localparam int PIX_PER_BYTE = tmpg_pkg::PIX_PER_BYTE;
  localparam int NUM_CODES    = tmpg_pkg::NUM_CODES;

  localparam int ROW_BYTES      = (GLYPH_W * PIX_W + 7) / 8;
  localparam int GLYPH_BYTES    = GLYPH_H * ROW_BYTES;
  localparam int FONT_BYTES     = NUM_CODES * GLYPH_BYTES;
  localparam int MAP_CELLS      = MAP_ROWS * MAP_COLS;
  localparam int BYTES_PER_LINE = VIDEO_W / PIX_PER_BYTE;
  localparam int LINE_MAX       = 2 ** LINE_W - 1;
  localparam int BCOL_MAX       = 2 ** BCOL_W - 1;
  localparam int COL_MAX        = 2 ** COL_W - 1;
  localparam int FADDR_MAX      = 2 ** FADDR_W - 1;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam int IDLE_PCT      = 22;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 145;
  localparam int NUM_PHASES    = 5;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [ROW_W-1:0]   cell_row;
    logic [COL_W-1:0]   cell_column;
    logic [CODE_W-1:0]  char_code;
    logic [FADDR_W-1:0] font_address;
    logic [BYTE_W-1:0]  font_byte;
    logic [LINE_W-1:0]  scan_line;
    logic [BCOL_W-1:0]  byte_column;
  } cmd_item_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [PIX_W-1:0] cfg_wdata;
  int               errors;
  int               pending;

  tmpg_cmd_if cmd ();
  tmpg_res_if res ();

  bit no_idle      = 1'b0;
  bit hold_request = 1'b0;
  bit hold_done    = 1'b0;
  int hold_count   = 0;
  int useful_items = 0;

  // stimulus bookkeeping: which map cells and font bytes are loaded
  logic [CODE_W-1:0] screen_codes [MAP_CELLS];
  bit                cell_loaded  [MAP_CELLS];
  bit                font_loaded  [FONT_BYTES];

  text_mode_pixel_generator #(
    .VIDEO_W (VIDEO_W),
    .VIDEO_H (VIDEO_H),
    .MAP_ROWS(MAP_ROWS),
    .MAP_COLS(MAP_COLS),
    .GLYPH_W (GLYPH_W),
    .GLYPH_H (GLYPH_H)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .cmd      (cmd),
    .res      (res)
  );

  tmpg_checker #(
    .VIDEO_W (VIDEO_W),
    .VIDEO_H (VIDEO_H),
    .MAP_ROWS(MAP_ROWS),
    .MAP_COLS(MAP_COLS),
    .GLYPH_W (GLYPH_W),
    .GLYPH_H (GLYPH_H)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .cmd           (cmd),
    .res           (res),
    .mismatch_count(errors),
    .outstanding   (pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side: random idling, one long hold-off, a stretch with no idling
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (hold_request && !hold_done) begin
      res.ready  <= 1'b0;
      hold_count <= hold_count + 1;
      if (hold_count == HOLD_CYCLES - 1) hold_done <= 1'b1;
    end else if (no_idle) begin
      res.ready <= 1'b1;
    end else begin
      res.ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic cmd_item_t random_item();
    cmd_item_t c;
    c.func         = FUNC_UNUSED;
    c.cell_row     = ROW_W'($urandom_range(2 ** ROW_W - 1));
    c.cell_column  = COL_W'($urandom_range(COL_MAX));
    c.char_code    = CODE_W'($urandom_range(NUM_CODES - 1));
    c.font_address = FADDR_W'($urandom_range(FADDR_MAX));
    c.font_byte    = BYTE_W'($urandom_range(2 ** BYTE_W - 1));
    c.scan_line    = LINE_W'($urandom_range(LINE_MAX));
    c.byte_column  = BCOL_W'($urandom_range(BCOL_MAX));
    return c;
  endfunction

  function automatic int pick_code();
    return ($urandom_range(99) < 70) ? $urandom_range(7) : $urandom_range(NUM_CODES - 1);
  endfunction

  task automatic offer(input cmd_item_t c);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.valid        <= 1'b1;
    cmd.func         <= c.func;
    cmd.cell_row     <= c.cell_row;
    cmd.cell_column  <= c.cell_column;
    cmd.char_code    <= c.char_code;
    cmd.font_address <= c.font_address;
    cmd.font_byte    <= c.font_byte;
    cmd.scan_line    <= c.scan_line;
    cmd.byte_column  <= c.byte_column;
    do @(posedge clk); while (!cmd.ready);
  endtask

  task automatic write_cell(input int row, input int col, input int code);
    cmd_item_t c;
    c             = random_item();
    c.func        = tmpg_pkg::FUNC_CELL_WR;
    c.cell_row    = ROW_W'(row);
    c.cell_column = COL_W'(col);
    c.char_code   = CODE_W'(code);
    if (row < MAP_ROWS && col < MAP_COLS) begin
      screen_codes[row * MAP_COLS + col] = CODE_W'(code);
      cell_loaded[row * MAP_COLS + col]  = 1'b1;
      useful_items++;
    end
    offer(c);
  endtask

  task automatic write_font(input int addr, input int data);
    cmd_item_t c;
    c              = random_item();
    c.func         = tmpg_pkg::FUNC_FONT_WR;
    c.font_address = FADDR_W'(addr);
    c.font_byte    = BYTE_W'(data);
    if (addr < FONT_BYTES) begin
      font_loaded[addr] = 1'b1;
      useful_items++;
    end
    offer(c);
  endtask

  task automatic read_frame(input int line, input int bcol);
    cmd_item_t c;
    c             = random_item();
    c.func        = tmpg_pkg::FUNC_READ;
    c.scan_line   = LINE_W'(line);
    c.byte_column = BCOL_W'(bcol);
    useful_items++;
    offer(c);
  endtask

  // loads the one map entry and font byte a frame byte covers, then reads it
  task automatic read_loaded(input int line, input int bcol);
    int map_idx;
    int addr;
    if (line < VIDEO_H && bcol < BYTES_PER_LINE) begin
      map_idx = (line / GLYPH_H) * MAP_COLS + (bcol * PIX_PER_BYTE) / GLYPH_W;
      if (!cell_loaded[map_idx])
        write_cell(map_idx / MAP_COLS, map_idx % MAP_COLS, pick_code());
      addr = screen_codes[map_idx] * GLYPH_BYTES + (line % GLYPH_H) * ROW_BYTES
             + ((bcol * PIX_PER_BYTE) % GLYPH_W) * PIX_W / 8;
      if (!font_loaded[addr]) write_font(addr, $urandom_range(2 ** BYTE_W - 1));
    end
    read_frame(line, bcol);
  endtask

  task automatic random_step();
    int        pick;
    cmd_item_t c;
    pick = $urandom_range(99);
    if (pick < 30) begin
      read_loaded($urandom_range(2 * GLYPH_H - 1), $urandom_range(BYTES_PER_LINE - 1));
    end else if (pick < 55) begin
      read_loaded($urandom_range(VIDEO_H - 1), $urandom_range(BYTES_PER_LINE - 1));
    end else if (pick < 65) begin
      if ($urandom_range(1))
        read_frame($urandom_range(LINE_MAX, VIDEO_H), $urandom_range(BCOL_MAX));
      else
        read_frame($urandom_range(LINE_MAX), $urandom_range(BCOL_MAX, BYTES_PER_LINE));
    end else if (pick < 78) begin
      write_cell($urandom_range(MAP_ROWS - 1), $urandom_range(MAP_COLS - 1), pick_code());
    end else if (pick < 90) begin
      if ($urandom_range(99) < 60)
        write_font($urandom_range(8 * GLYPH_BYTES - 1), $urandom_range(2 ** BYTE_W - 1));
      else
        write_font($urandom_range(FONT_BYTES - 1), $urandom_range(2 ** BYTE_W - 1));
    end else if (pick < 95) begin
      if ($urandom_range(1))
        write_cell($urandom_range(MAP_ROWS - 1), $urandom_range(COL_MAX, MAP_COLS),
                   $urandom_range(NUM_CODES - 1));
      else
        write_font($urandom_range(FADDR_MAX, FONT_BYTES), $urandom_range(2 ** BYTE_W - 1));
    end else begin
      c = random_item();
      offer(c);
    end
  endtask

  task automatic set_transparent(input logic [PIX_W-1:0] code);
    cfg_we    <= 1'b1;
    cfg_wdata <= code;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic drain();
    cmd.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [PIX_W-1:0] phase_code [NUM_PHASES];
    int               target;
    cmd_item_t        c;
    phase_code = '{2'd1, 2'd2, 2'd0, 2'd3, 2'd0};
    phase_code[NUM_PHASES-1] = PIX_W'($urandom_range(3));

    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    cmd.valid        <= 1'b0;
    cmd.func         <= '0;
    cmd.cell_row     <= '0;
    cmd.cell_column  <= '0;
    cmd.char_code    <= '0;
    cmd.font_address <= '0;
    cmd.font_byte    <= '0;
    cmd.scan_line    <= '0;
    cmd.byte_column  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    set_transparent(2'd3);

    // zero glyph pixels stay zero inside the grid
    write_cell(0, 0, 0);
    write_font(0, 8'h00);
    read_loaded(0, 0);
    write_font(1, 8'h1B);
    read_loaded(0, 1);
    // last map entry, last glyph, last font byte
    write_cell(MAP_ROWS - 1, MAP_COLS - 1, NUM_CODES - 1);
    write_font(FONT_BYTES - 1, 8'hFF);
    read_loaded(VIDEO_H - 1, BYTES_PER_LINE - 1);
    // writes past the map and past font memory
    write_cell(3, MAP_COLS, 8'hAA);
    write_cell(MAP_ROWS - 1, COL_MAX, 8'h55);
    write_font(FONT_BYTES, 8'hFF);
    write_font(FADDR_MAX, 8'hA5);
    read_loaded(0, 0);
    // reads outside the frame
    read_frame(VIDEO_H, 0);
    read_frame(LINE_MAX, BCOL_MAX);
    read_frame(0, BYTES_PER_LINE);
    c = random_item();
    offer(c);
    // remap an entry to another glyph
    write_cell(0, 0, 1);
    write_font(GLYPH_BYTES, 8'hE4);
    read_loaded(0, 0);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_transparent(phase_code[p]);
      no_idle <= (p == 2);
      if (p == 1) hold_request <= 1'b1;
      target = useful_items + PHASE_ITEMS;
      while (useful_items < target) random_step();
      drain();
    end

    if (errors == 0 && pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
